// ----- rtl/baro_sensor_compensation_defines.svh -----
// ----------------------------------------------------------------------------
// baro sensor compensation assertion macros
// shared concurrent check forms, sampled on clk, off during reset
// ----------------------------------------------------------------------------
`ifndef BARO_SENSOR_COMPENSATION_DEFINES_SVH
`define BARO_SENSOR_COMPENSATION_DEFINES_SVH

// same-cycle implication
`define BSC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/bsc_pkg.sv -----
// ----------------------------------------------------------------------------
// bsc_pkg
// widths, constants and shared types of the barometric compensation pipeline
// ----------------------------------------------------------------------------
package bsc_pkg;

    localparam int RAW_W     = 24;
    localparam int CAL_W     = 16;
    localparam int TEMP_W    = 19;
    localparam int PRES_W    = 23;
    localparam int CFG_IDX_W = 3;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 48;
    localparam int OUT_PAD_W   = OUT_TDATA_W - TEMP_W - PRES_W;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SENS_BASE        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BASE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SENS_TEMP_COEF   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_TEMP_COEF = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REF_TEMPERATURE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_SLOPE       = 3'd5;

    // internal widths
    localparam int DT_W    = 25;
    localparam int PROD_W  = 42;
    localparam int OFF_W   = 40;
    localparam int SENS_W  = 38;
    localparam int DIFF_W  = 20;
    localparam int SQ_W    = 34;
    localparam int OFF2_W  = 38;
    localparam int SENS2_W = 37;
    localparam int SL_W    = 19;
    localparam int SH_W    = SENS_W - SL_W;
    localparam int PL_W    = RAW_W + SL_W;
    localparam int PH_W    = RAW_W + 1 + SH_W;
    localparam int FULL_W  = 64;
    localparam int X_W     = 44;

    // shifts
    localparam int TREF_SHIFT  = 8;
    localparam int TEMP_SHIFT  = 23;
    localparam int OFF_SHIFT   = 7;
    localparam int SENS_SHIFT  = 8;
    localparam int OFFB_SHIFT  = 16;
    localparam int SENSB_SHIFT = 15;
    localparam int PROD_SHIFT  = 21;
    localparam int P_SHIFT     = 15;

    // temperature thresholds and ranges, 0.01 degC
    localparam int TEMP_LOW_CENTI      = 2000;
    localparam int TEMP_VERY_LOW_CENTI = -1500;
    localparam int TEMP_MIN_CENTI      = -129068;
    localparam int TEMP_MAX_CENTI      = 133070;

    // pressure limits, Pa
    localparam int P_MIN = -4194304;
    localparam int P_MAX = 4194303;

    typedef struct packed {
        logic        [RAW_W-1:0]  d1;
        logic signed [OFF_W-1:0]  off;
        logic signed [SENS_W-1:0] sens;
        logic signed [TEMP_W-1:0] temp;
    } pres_in_t;

endpackage

// ----- rtl/bsc_pres.sv -----
// ----------------------------------------------------------------------------
// bsc_pres
// pressure back end: split raw x sensitivity product, offset and saturation
// ----------------------------------------------------------------------------
module bsc_pres
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  bsc_pkg::pres_in_t                      in_word,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [bsc_pkg::TEMP_W-1:0]      out_temp,
    output logic signed [bsc_pkg::PRES_W-1:0]      out_pres
);

    localparam int NSTG = 4;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_up;
    logic [NSTG-1:0] rdy;

    // stage 1: partial products
    logic        [bsc_pkg::PL_W-1:0]   pl_reg, pl_next;
    logic signed [bsc_pkg::PH_W-1:0]   ph_reg, ph_next;
    logic signed [bsc_pkg::OFF_W-1:0]  off1_reg;
    logic signed [bsc_pkg::TEMP_W-1:0] temp1_reg;
    // stage 2: full product
    logic signed [bsc_pkg::FULL_W-1:0] full_reg, full_next;
    logic signed [bsc_pkg::OFF_W-1:0]  off2_reg;
    logic signed [bsc_pkg::TEMP_W-1:0] temp2_reg;
    // stage 3: offset removed
    logic signed [bsc_pkg::X_W-1:0]    x_reg, x_next;
    logic signed [bsc_pkg::TEMP_W-1:0] temp3_reg;
    // stage 4: output
    logic signed [bsc_pkg::X_W-1:0]    y;
    logic signed [bsc_pkg::PRES_W-1:0] pres_reg, pres_next;
    logic signed [bsc_pkg::TEMP_W-1:0] temp4_reg;

    assign vld_up = {vld_reg[NSTG-2:0], in_valid};

    always_comb
    begin
        rdy[NSTG-1] = !vld_reg[NSTG-1] || out_ready;
        for (int k = NSTG - 2; k >= 0; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    assign in_ready = rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NSTG; k++)
            begin
                if (rdy[k])
                begin
                    vld_reg[k] <= vld_up[k];
                end
            end
        end
    end

    always_comb
    begin
        pl_next = bsc_pkg::PL_W'(in_word.d1) * bsc_pkg::PL_W'(in_word.sens[bsc_pkg::SL_W-1:0]);
        ph_next = $signed({1'b0, in_word.d1})
                  * $signed(in_word.sens[bsc_pkg::SENS_W-1:bsc_pkg::SL_W]);
        full_next = ($signed(bsc_pkg::FULL_W'(ph_reg)) <<< bsc_pkg::SL_W)
                    + $signed(bsc_pkg::FULL_W'(pl_reg));
        x_next = bsc_pkg::X_W'(full_reg >>> bsc_pkg::PROD_SHIFT)
                 - bsc_pkg::X_W'(off2_reg);
        y = x_reg >>> bsc_pkg::P_SHIFT;
        if (y < bsc_pkg::X_W'(bsc_pkg::P_MIN))
        begin
            pres_next = bsc_pkg::PRES_W'(bsc_pkg::P_MIN);
        end
        else if (y > bsc_pkg::X_W'(bsc_pkg::P_MAX))
        begin
            pres_next = bsc_pkg::PRES_W'(bsc_pkg::P_MAX);
        end
        else
        begin
            pres_next = y[bsc_pkg::PRES_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            pl_reg    <= pl_next;
            ph_reg    <= ph_next;
            off1_reg  <= in_word.off;
            temp1_reg <= in_word.temp;
        end
        if (rdy[1])
        begin
            full_reg  <= full_next;
            off2_reg  <= off1_reg;
            temp2_reg <= temp1_reg;
        end
        if (rdy[2])
        begin
            x_reg     <= x_next;
            temp3_reg <= temp2_reg;
        end
        if (rdy[3])
        begin
            pres_reg  <= pres_next;
            temp4_reg <= temp3_reg;
        end
    end

    assign out_valid = vld_reg[NSTG-1];
    assign out_temp  = temp4_reg;
    assign out_pres  = pres_reg;

endmodule

// ----- rtl/baro_sensor_compensation.sv -----
// ----------------------------------------------------------------------------
// baro_sensor_compensation
// an accepted word passes through all register stages before its result word appears on m_tdata
// throughput: one word per cycle while m_tready does not stall the output; ten register
//   stages, the widest being the split 24 x 38 bit pressure product over two stages
// reset: rst_n clears all valid bits and the six calibration registers to 0
// ----------------------------------------------------------------------------
module baro_sensor_compensation
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [bsc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bsc_pkg::CAL_W-1:0]          cfg_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // raw_pressure[23:0], raw_temperature[47:24]
    input  logic [bsc_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // temperature_centi[18:0], pressure_pa[41:19], zero[47:42]
    output logic [bsc_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    localparam int NSTG = 6;
    localparam logic signed [bsc_pkg::PROD_W-1:0] TEMP_BIAS =
        bsc_pkg::PROD_W'((64'sd1 <<< bsc_pkg::TEMP_SHIFT) - 64'sd1);

    // calibration registers
    logic [bsc_pkg::CAL_W-1:0] sens_base_reg;
    logic [bsc_pkg::CAL_W-1:0] offset_base_reg;
    logic [bsc_pkg::CAL_W-1:0] sens_temp_coef_reg;
    logic [bsc_pkg::CAL_W-1:0] offset_temp_coef_reg;
    logic [bsc_pkg::CAL_W-1:0] ref_temperature_reg;
    logic [bsc_pkg::CAL_W-1:0] temp_slope_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sens_base_reg        <= '0;
            offset_base_reg      <= '0;
            sens_temp_coef_reg   <= '0;
            offset_temp_coef_reg <= '0;
            ref_temperature_reg  <= '0;
            temp_slope_reg       <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bsc_pkg::REG_SENS_BASE:        sens_base_reg        <= cfg_data;
                bsc_pkg::REG_OFFSET_BASE:      offset_base_reg      <= cfg_data;
                bsc_pkg::REG_SENS_TEMP_COEF:   sens_temp_coef_reg   <= cfg_data;
                bsc_pkg::REG_OFFSET_TEMP_COEF: offset_temp_coef_reg <= cfg_data;
                bsc_pkg::REG_REF_TEMPERATURE:  ref_temperature_reg  <= cfg_data;
                bsc_pkg::REG_TEMP_SLOPE:       temp_slope_reg       <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // pipeline control
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_up;
    logic [NSTG-1:0] rdy;
    logic            pres_ready;

    assign vld_up = {vld_reg[NSTG-2:0], s_tvalid};

    always_comb
    begin
        rdy[NSTG-1] = !vld_reg[NSTG-1] || pres_ready;
        for (int k = NSTG - 2; k >= 0; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    assign s_tready = rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NSTG; k++)
            begin
                if (rdy[k])
                begin
                    vld_reg[k] <= vld_up[k];
                end
            end
        end
    end

    // stage datapath registers
    logic        [bsc_pkg::RAW_W-1:0]   d1_reg [NSTG];
    logic signed [bsc_pkg::DT_W-1:0]    dt_reg, dt_next;
    logic signed [bsc_pkg::PROD_W-1:0]  pt_reg, pt_next;
    logic signed [bsc_pkg::PROD_W-1:0]  po_reg, po_next;
    logic signed [bsc_pkg::PROD_W-1:0]  ps_reg, ps_next;
    logic signed [bsc_pkg::TEMP_W-1:0]  temp3_reg, temp3_next;
    logic signed [bsc_pkg::TEMP_W-1:0]  temp4_reg, temp5_reg, temp6_reg;
    logic signed [bsc_pkg::OFF_W-1:0]   off1_reg, off1_next, off4_reg, off5_reg;
    logic signed [bsc_pkg::SENS_W-1:0]  sens1_reg, sens1_next, sens4_reg, sens5_reg;
    logic        [bsc_pkg::SQ_W-1:0]    q_reg, q_next;
    logic        [bsc_pkg::SQ_W-1:0]    r_reg, r_next;
    logic        [bsc_pkg::OFF2_W-1:0]  off2_reg, off2_next;
    logic        [bsc_pkg::SENS2_W-1:0] sens2_reg, sens2_next;
    logic signed [bsc_pkg::OFF_W-1:0]   off_reg, off_next;
    logic signed [bsc_pkg::SENS_W-1:0]  sens_reg, sens_next;

    logic signed [bsc_pkg::PROD_W-1:0]   pt_round;
    logic signed [bsc_pkg::PROD_W-1:0]   temp_sum;
    logic signed [bsc_pkg::DIFF_W-1:0]   dlo;
    logic signed [bsc_pkg::DIFF_W-1:0]   dvl;
    logic signed [2*bsc_pkg::DIFF_W-1:0] dlo_sq;
    logic signed [2*bsc_pkg::DIFF_W-1:0] dvl_sq;
    logic                                temp_lo;
    logic                                temp_vlo;
    logic        [bsc_pkg::SQ_W+2:0]     q5;
    logic        [bsc_pkg::SQ_W+2:0]     r7;
    logic        [bsc_pkg::SQ_W+3:0]     r11;

    always_comb
    begin
        // stage 1: temperature difference
        dt_next = $signed({1'b0, s_tdata[2*bsc_pkg::RAW_W-1:bsc_pkg::RAW_W]})
                  - $signed({1'b0, ref_temperature_reg, {bsc_pkg::TREF_SHIFT{1'b0}}});

        // stage 2: first-order products
        pt_next = dt_reg * $signed({1'b0, temp_slope_reg});
        po_next = dt_reg * $signed({1'b0, offset_temp_coef_reg});
        ps_next = dt_reg * $signed({1'b0, sens_temp_coef_reg});

        // stage 3: temperature, truncated toward zero, and first-order terms
        pt_round   = pt_reg[bsc_pkg::PROD_W-1] ? (pt_reg + TEMP_BIAS) : pt_reg;
        temp_sum   = (pt_round >>> bsc_pkg::TEMP_SHIFT)
                     + bsc_pkg::PROD_W'(bsc_pkg::TEMP_LOW_CENTI);
        temp3_next = temp_sum[bsc_pkg::TEMP_W-1:0];
        off1_next  = $signed(bsc_pkg::OFF_W'({offset_base_reg,
                                              {bsc_pkg::OFFB_SHIFT{1'b0}}}))
                     + bsc_pkg::OFF_W'(po_reg >>> bsc_pkg::OFF_SHIFT);
        sens1_next = $signed(bsc_pkg::SENS_W'({sens_base_reg,
                                               {bsc_pkg::SENSB_SHIFT{1'b0}}}))
                     + bsc_pkg::SENS_W'(ps_reg >>> bsc_pkg::SENS_SHIFT);

        // stage 4: squares for the low-temperature correction
        temp_lo  = temp3_reg < bsc_pkg::TEMP_W'(bsc_pkg::TEMP_LOW_CENTI);
        temp_vlo = temp3_reg < bsc_pkg::TEMP_W'(bsc_pkg::TEMP_VERY_LOW_CENTI);
        dlo      = bsc_pkg::DIFF_W'(temp3_reg) - bsc_pkg::DIFF_W'(bsc_pkg::TEMP_LOW_CENTI);
        dvl      = bsc_pkg::DIFF_W'(temp3_reg)
                   - bsc_pkg::DIFF_W'(bsc_pkg::TEMP_VERY_LOW_CENTI);
        dlo_sq   = dlo * dlo;
        dvl_sq   = dvl * dvl;
        q_next   = temp_lo  ? dlo_sq[bsc_pkg::SQ_W-1:0] : '0;
        r_next   = temp_vlo ? dvl_sq[bsc_pkg::SQ_W-1:0] : '0;

        // stage 5: correction amounts
        q5  = {1'b0, q_reg, 2'b00} + {3'b000, q_reg};
        r7  = {r_reg, 3'b000} - {3'b000, r_reg};
        r11 = {1'b0, r_reg, 3'b000} + {2'b00, r_reg, 2'b00}
              - {4'b0000, r_reg};
        off2_next  = bsc_pkg::OFF2_W'(q5 >> 1) + bsc_pkg::OFF2_W'(r7);
        sens2_next = bsc_pkg::SENS2_W'(q5 >> 2) + bsc_pkg::SENS2_W'(r11 >> 1);

        // stage 6: corrected offset and sensitivity
        off_next  = off5_reg - $signed(bsc_pkg::OFF_W'(off2_reg));
        sens_next = sens5_reg - $signed(bsc_pkg::SENS_W'(sens2_reg));
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            d1_reg[0] <= s_tdata[bsc_pkg::RAW_W-1:0];
            dt_reg    <= dt_next;
        end
        if (rdy[1])
        begin
            d1_reg[1] <= d1_reg[0];
            pt_reg    <= pt_next;
            po_reg    <= po_next;
            ps_reg    <= ps_next;
        end
        if (rdy[2])
        begin
            d1_reg[2] <= d1_reg[1];
            temp3_reg <= temp3_next;
            off1_reg  <= off1_next;
            sens1_reg <= sens1_next;
        end
        if (rdy[3])
        begin
            d1_reg[3] <= d1_reg[2];
            temp4_reg <= temp3_reg;
            off4_reg  <= off1_reg;
            sens4_reg <= sens1_reg;
            q_reg     <= q_next;
            r_reg     <= r_next;
        end
        if (rdy[4])
        begin
            d1_reg[4] <= d1_reg[3];
            temp5_reg <= temp4_reg;
            off5_reg  <= off4_reg;
            sens5_reg <= sens4_reg;
            off2_reg  <= off2_next;
            sens2_reg <= sens2_next;
        end
        if (rdy[5])
        begin
            d1_reg[5] <= d1_reg[4];
            temp6_reg <= temp5_reg;
            off_reg   <= off_next;
            sens_reg  <= sens_next;
        end
    end

    // pressure back end
    bsc_pkg::pres_in_t                 pres_word;
    logic signed [bsc_pkg::TEMP_W-1:0] out_temp;
    logic signed [bsc_pkg::PRES_W-1:0] out_pres;

    always_comb
    begin
        pres_word.d1   = d1_reg[NSTG-1];
        pres_word.off  = off_reg;
        pres_word.sens = sens_reg;
        pres_word.temp = temp6_reg;
    end

    bsc_pres u_pres
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vld_reg[NSTG-1]),
        .in_ready  (pres_ready),
        .in_word   (pres_word),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_temp  (out_temp),
        .out_pres  (out_pres)
    );

    assign m_tdata = {{bsc_pkg::OUT_PAD_W{1'b0}}, out_pres, out_temp};

`include "baro_sensor_compensation_defines.svh"

    `BSC_ASSERT_NEXT(a_accept_lands, s_tvalid && s_tready, vld_reg[0], "accepted word lost at entry")
    `BSC_ASSERT_IMPL(a_full_stall, (&vld_reg) && !pres_ready, !s_tready, "input taken while front end full and stalled")
    `BSC_ASSERT_IMPL(a_temp_range, m_tvalid, ($signed(out_temp) >= bsc_pkg::TEMP_W'(bsc_pkg::TEMP_MIN_CENTI)) && ($signed(out_temp) <= bsc_pkg::TEMP_W'(bsc_pkg::TEMP_MAX_CENTI)), "temperature word out of range")

endmodule
